FILE: rtl/wbsd_pkg.sv
// shared widths and defaults for the window baseline settle detector
package wbsd_pkg;

	localparam int SAMPLE_W       = 24;
	localparam int SUM_W          = 28;
	localparam int TOL_W          = 16;
	localparam int WINDOW_DEFAULT = 10;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(13);

	// stage 1 status handed to the deviation check
	typedef struct packed {
		logic valid;
		logic full;
	} wbsd_stage_t;

endpackage

FILE: rtl/wbsd_if.sv
// sample and result channel interfaces
interface wbsd_in_if;
	import wbsd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       clear;

	modport source (output valid, output sample, output clear, input ready);
	modport sink   (input valid, input sample, input clear, output ready);
endinterface

interface wbsd_out_if;
	import wbsd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    settled;
	logic                    window_full;
	logic signed [SUM_W-1:0] window_sum;

	modport source (output valid, output settled, output window_full, output window_sum,
		input ready);
	modport sink   (input valid, input settled, input window_full, input window_sum,
		output ready);
endinterface

FILE: rtl/wbsd_window.sv
// sample history shift line, running sum and fill counter
module wbsd_window
	import wbsd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  logic                       in_clear,
	input  logic                       take,
	output wbsd_stage_t                stage_s1,
	output logic signed [SAMPLE_W-1:0] hist_q [WINDOW],
	output logic signed [SUM_W-1:0]    sum_q
);

	localparam int FILL_W = $clog2(WINDOW + 2);

	logic              accept;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_base;
	logic [FILL_W-1:0] fill_nxt;

	assign in_ready = !stage_s1.valid || take;
	assign accept   = in_valid && in_ready;

	// clear restarts the count only, history keeps sliding
	assign fill_base = in_clear ? '0 : fill_q;
	assign fill_nxt  = (fill_base < FILL_W'(WINDOW + 1)) ? fill_base + FILL_W'(1) : fill_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				stage_s1.valid <= 1'b1;
				stage_s1.full  <= fill_nxt > FILL_W'(WINDOW);
				fill_q         <= fill_nxt;
				sum_q          <= sum_q + SUM_W'(in_sample) - SUM_W'(hist_q[WINDOW-1]);
				hist_q[0]      <= in_sample;
				for (int i = 1; i < WINDOW; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end else if (take) begin
				stage_s1.valid <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/wbsd_check.sv
// parallel deviation compares and result register
module wbsd_check
	import wbsd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wbsd_stage_t                stage_s1,
	input  logic signed [SAMPLE_W-1:0] hist_q [WINDOW],
	input  logic signed [SUM_W-1:0]    sum_q,
	input  logic [TOL_W-1:0]           tol,
	output logic                       take,
	wbsd_out_if.source                 dout
);

	localparam int PROD_W = SAMPLE_W + $clog2(WINDOW) + 1;
	localparam int DIFF_W = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
	localparam int LIM_W  = TOL_W + $clog2(WINDOW) + 1;
	localparam int CMP_W  = (DIFF_W > LIM_W) ? DIFF_W : LIM_W;

	logic [LIM_W-1:0]  limit;
	logic [WINDOW-1:0] tap_ok;
	logic              valid_q;

	assign limit = LIM_W'(tol) * LIM_W'(WINDOW);

	// one comparator per window tap
	for (genvar i = 0; i < WINDOW; i++) begin : g_tap
		logic signed [PROD_W-1:0] prod;
		logic signed [DIFF_W-1:0] diff;
		logic        [DIFF_W-1:0] mag;

		assign prod      = PROD_W'(hist_q[i]) * $signed(PROD_W'(WINDOW));
		assign diff      = DIFF_W'(prod) - DIFF_W'(sum_q);
		assign mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		assign tap_ok[i] = CMP_W'(mag) <= CMP_W'(limit);
	end

	assign take       = !valid_q || dout.ready;
	assign dout.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && stage_s1.valid) begin
			dout.settled     <= stage_s1.full && (&tap_ok);
			dout.window_full <= stage_s1.full;
			dout.window_sum  <= sum_q;
		end
	end

endmodule

FILE: rtl/window_baseline_settle_detector.sv
// top level of the window baseline settle detector
// Takes one signed 24-bit sample (8 fraction bits) per beat on din and returns one result
// beat on dout: the sum of the last WINDOW samples, a window_full flag once more than
// WINDOW samples have arrived since the last clear, and settled when the window is full and
// every windowed sample s satisfies |WINDOW*s - sum| <= WINDOW*tolerance. Throughput is one
// beat per clock while dout is ready; each din beat is registered first in the history/sum
// update, then the parallel per-tap compare is registered into the dout result register.
// A sample with clear set restarts the fill count only: history and sum keep sliding.
// The tolerance register resets to 13 and is written through cfg_we/cfg_wdata; write it
// only while no beat is in flight.
module window_baseline_settle_detector
	import wbsd_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [TOL_W-1:0] cfg_wdata,
	wbsd_in_if.sink          din,
	wbsd_out_if.source       dout
);

	// tolerance register
	logic [TOL_W-1:0] tol_q;

	// stage 1: window state after the newest sample
	wbsd_stage_t                stage_s1;
	logic signed [SAMPLE_W-1:0] hist_q [WINDOW];
	logic signed [SUM_W-1:0]    sum_q;

	// result register can take the stage 1 item this cycle
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// history shift line, running sum, fill counter
	wbsd_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.in_sample (din.sample),
		.in_clear  (din.clear),
		.take      (take),
		.stage_s1  (stage_s1),
		.hist_q    (hist_q),
		.sum_q     (sum_q)
	);

	// per-tap deviation test and output register
	wbsd_check #(
		.WINDOW (WINDOW)
	) u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage_s1 (stage_s1),
		.hist_q   (hist_q),
		.sum_q    (sum_q),
		.tol      (tol_q),
		.take     (take),
		.dout     (dout)
	);

endmodule
